@@ design/zcpe_pkg.sv @@
package zcpe_pkg;

    localparam int TIME_W = 32;
    localparam int POS_W = 32;
    localparam int PROD_W = TIME_W + POS_W;
    localparam int SUM_W = POS_W + 1;
    localparam int STEP_W = $clog2(TIME_W);
    localparam int CNT_W = 2;

    localparam logic [CNT_W-1:0] CROSSINGS_FOR_PERIOD = CNT_W'(3);

    typedef struct packed {
        logic                    run_start;
        logic [TIME_W-1:0]       sample_time;
        logic signed [POS_W-1:0] position;
    } sample_t;

    typedef struct packed {
        logic [TIME_W-1:0] period;
        logic              period_valid;
        logic [CNT_W-1:0]  crossings_seen;
    } result_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic mul;
        logic div_init;
        logic div_step;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic crossing;
        logic sum_zero;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

@@ design/zcpe_ctrl.sv @@
module zcpe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_ready,
    input  zcpe_pkg::dp_status_t status,
    output zcpe_pkg::dp_cmd_t    cmd
);
    import zcpe_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVAL  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_DINIT = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        sample_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (status.crossing && !status.sum_zero)
                    state_next = ST_MUL;
                else
                    state_next = ST_DONE;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DINIT;
            end
            ST_DINIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ design/zcpe_datapath.sv @@
module zcpe_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  zcpe_pkg::sample_t    sample,
    input  zcpe_pkg::dp_cmd_t    cmd,
    output zcpe_pkg::dp_status_t status,
    output logic                 result_valid,
    input  logic                 result_ready,
    output zcpe_pkg::result_t    result
);
    import zcpe_pkg::*;

    // run state
    logic [TIME_W-1:0] prev_time_reg, prev_time_next;
    logic [POS_W-1:0]  prev_pos_reg, prev_pos_next;
    logic              have_prev_reg, have_prev_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TIME_W-1:0] first_reg, first_next;
    logic [TIME_W-1:0] held_reg, held_next;
    logic              out_valid_reg, out_valid_next;

    // working registers
    logic [TIME_W-1:0] cur_time_reg;
    logic [POS_W-1:0]  cur_pos_reg;
    logic              crossing_reg;
    logic              sum_zero_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [TIME_W-1:0] base_reg;
    logic [SUM_W-1:0]  rem_reg;
    logic [TIME_W-1:0] low_reg;
    logic [TIME_W-1:0] quot_reg;
    logic [STEP_W-1:0] step_reg;
    result_t           out_data_reg;

    logic              x0_neg, x1_neg, z0, z1;
    logic [POS_W-1:0]  mag0, mag1;
    logic [SUM_W-1:0]  sum_w;
    logic              forward;
    logic [TIME_W-1:0] delta;
    logic [POS_W-1:0]  mult_sel;
    logic [TIME_W-1:0] base_sel;
    logic [SUM_W:0]    trial;
    logic              fits;
    logic [TIME_W-1:0] cross_time;
    logic [CNT_W-1:0]  count_inc;
    logic              out_free;

    assign x0_neg = prev_pos_reg[POS_W-1];
    assign x1_neg = cur_pos_reg[POS_W-1];
    assign z0     = (prev_pos_reg == '0);
    assign z1     = (cur_pos_reg == '0);
    assign mag0   = x0_neg ? (~prev_pos_reg + POS_W'(1)) : prev_pos_reg;
    assign mag1   = x1_neg ? (~cur_pos_reg + POS_W'(1)) : cur_pos_reg;
    assign sum_w  = {1'b0, mag0} + {1'b0, mag1};

    assign forward  = (cur_time_reg >= prev_time_reg);
    assign delta    = forward ? (cur_time_reg - prev_time_reg) : (prev_time_reg - cur_time_reg);
    assign mult_sel = forward ? mag0 : mag1;
    assign base_sel = forward ? prev_time_reg : cur_time_reg;

    // restoring divide, one quotient bit per cycle
    assign trial = {rem_reg, low_reg[TIME_W-1]};
    assign fits  = (trial >= {1'b0, sum_reg});

    assign cross_time = sum_zero_reg ? prev_time_reg : (base_reg + quot_reg);
    assign count_inc  = count_reg + CNT_W'(1);
    assign out_free   = !out_valid_reg || result_ready;

    assign status.crossing = have_prev_reg && (count_reg != CROSSINGS_FOR_PERIOD)
                             && (z0 || z1 || (x0_neg != x1_neg));
    assign status.sum_zero = (sum_w == '0);
    assign status.div_last = (step_reg == STEP_W'(TIME_W - 1));
    assign status.out_free = out_free;

    always_comb
    begin
        prev_time_next = prev_time_reg;
        prev_pos_next  = prev_pos_reg;
        have_prev_next = have_prev_reg;
        count_next     = count_reg;
        first_next     = first_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg;
        if (result_ready)
            out_valid_next = 1'b0;
        if (cmd.load && sample.run_start)
        begin
            have_prev_next = 1'b0;
            count_next     = '0;
            first_next     = '0;
            held_next      = '0;
        end
        if (cmd.commit)
        begin
            if (crossing_reg)
            begin
                count_next = count_inc;
                if (count_reg == '0)
                    first_next = cross_time;
                if (count_inc == CROSSINGS_FOR_PERIOD)
                    held_next = cross_time - first_reg;
            end
            prev_time_next = cur_time_reg;
            prev_pos_next  = cur_pos_reg;
            have_prev_next = 1'b1;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg <= '0;
            prev_pos_reg  <= '0;
            have_prev_reg <= 1'b0;
            count_reg     <= '0;
            first_reg     <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prev_time_reg <= prev_time_next;
            prev_pos_reg  <= prev_pos_next;
            have_prev_reg <= have_prev_next;
            count_reg     <= count_next;
            first_reg     <= first_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_time_reg <= sample.sample_time;
            cur_pos_reg  <= sample.position;
        end
        if (cmd.eval)
        begin
            crossing_reg <= status.crossing;
            sum_zero_reg <= status.sum_zero;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(delta) * PROD_W'(mult_sel);
            sum_reg  <= sum_w;
            base_reg <= base_sel;
        end
        if (cmd.div_init)
        begin
            rem_reg  <= {1'b0, prod_reg[PROD_W-1:TIME_W]};
            low_reg  <= prod_reg[TIME_W-1:0];
            quot_reg <= '0;
            step_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= fits ? SUM_W'(trial - {1'b0, sum_reg}) : trial[SUM_W-1:0];
            low_reg  <= {low_reg[TIME_W-2:0], 1'b0};
            quot_reg <= {quot_reg[TIME_W-2:0], fits};
            step_reg <= step_reg + STEP_W'(1);
        end
        if (cmd.commit)
        begin
            out_data_reg.period_valid   <= (count_next == CROSSINGS_FOR_PERIOD);
            out_data_reg.crossings_seen <= count_next;
            out_data_reg.period         <= (count_next == CROSSINGS_FOR_PERIOD) ? held_next : '0;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

@@ design/zero_crossing_period_estimator_core.sv @@
// sequence: a sample with no crossing to interpolate is accepted, evaluated and committed;
// one with a crossing also goes through multiply, divider setup and a radix-2 divide before commit
// busy: a new sample is accepted only after the previous one commits; the divider yields
// one quotient bit per cycle, and a full output register holds off the commit
// reset: rst_n asynchronous, clears previous sample, crossing count, first crossing,
// held period and the output valid flag
module zero_crossing_period_estimator_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  zcpe_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_ready,
    output zcpe_pkg::result_t result
);
    import zcpe_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    zcpe_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    zcpe_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // busy after each accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("sample accepted while block busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.period_valid == (result.crossings_seen == CROSSINGS_FOR_PERIOD)))
        else $error("period_valid disagrees with crossing count");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.period_valid |-> (result.period == '0))
        else $error("period nonzero before it is valid");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.eval, cmd.mul, cmd.div_init, cmd.div_step, cmd.commit}))
        else $error("more than one datapath command at once");

endmodule

@@ tb/tb_zero_crossing_period_estimator_core.sv @@
`timescale 1ns / 100ps

module tb_zero_crossing_period_estimator_core;

    import zcpe_pkg::*;

    typedef struct packed {
        sample_t s;
        logic    typed;
        result_t want;
    } dir_row_t;

    localparam int NUM_DIRECTED = 16;
    localparam int RANDOM_ITEMS = 900;

    logic    clk;
    logic    rst_n;
    logic    sample_valid;
    logic    sample_ready;
    sample_t sample;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    int src_idle_pct;
    int snk_idle_pct;
    int samples_sent;
    int results_checked;
    int mismatch_count;
    int periods_measured;
    int both_zero_pairs;
    int backward_pairs;

    logic [TIME_W-1:0] est_prev_time;
    logic [POS_W-1:0]  est_prev_pos;
    logic              est_have_prev;
    logic [CNT_W-1:0]  est_count;
    logic [TIME_W-1:0] est_first;
    logic [TIME_W-1:0] est_period;

    result_t  expected_results[$];
    dir_row_t directed_rows[NUM_DIRECTED];

    zero_crossing_period_estimator_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [POS_W:0] pos_abs(input logic [POS_W-1:0] x);
        logic [POS_W:0] ext;
        ext = {x[POS_W-1], x};
        return x[POS_W-1] ? ((POS_W+1)'(0) - ext) : ext;
    endfunction

    function automatic logic [TIME_W-1:0] interp_crossing(input logic [TIME_W-1:0] t0,
                                                          input logic [POS_W-1:0]  x0,
                                                          input logic [TIME_W-1:0] t1,
                                                          input logic [POS_W-1:0]  x1);
        logic [POS_W:0] a;
        logic [POS_W:0] b;
        logic [POS_W:0] s;
        logic [63:0]    q;
        a = pos_abs(x0);
        b = pos_abs(x1);
        s = a + b;
        if (s == '0)
            return t0;
        if (t1 >= t0)
        begin
            q = (64'(t1 - t0) * 64'(a)) / 64'(s);
            return t0 + q[TIME_W-1:0];
        end
        q = (64'(t0 - t1) * 64'(b)) / 64'(s);
        return t1 + q[TIME_W-1:0];
    endfunction

    function automatic result_t advance_estimate(input sample_t s);
        logic [TIME_W-1:0] tc;
        logic              crossing;
        result_t           r;
        if (s.run_start)
        begin
            est_have_prev = 1'b0;
            est_count     = '0;
            est_first     = '0;
            est_period    = '0;
        end
        if (est_have_prev && est_count != CROSSINGS_FOR_PERIOD)
        begin
            crossing = (est_prev_pos == '0) || (s.position == '0)
                       || (est_prev_pos[POS_W-1] != s.position[POS_W-1]);
            if (crossing)
            begin
                if (est_prev_pos == '0 && s.position == '0)
                    both_zero_pairs++;
                if (s.sample_time < est_prev_time)
                    backward_pairs++;
                tc = interp_crossing(est_prev_time, est_prev_pos, s.sample_time, s.position);
                if (est_count == '0)
                    est_first = tc;
                est_count = est_count + CNT_W'(1);
                if (est_count == CROSSINGS_FOR_PERIOD)
                begin
                    est_period = tc - est_first;
                    periods_measured++;
                end
            end
        end
        est_prev_time = s.sample_time;
        est_prev_pos  = s.position;
        est_have_prev = 1'b1;
        r.period         = (est_count == CROSSINGS_FOR_PERIOD) ? est_period : '0;
        r.period_valid   = (est_count == CROSSINGS_FOR_PERIOD);
        r.crossings_seen = est_count;
        return r;
    endfunction

    function automatic void flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t ERROR: %s", $time, msg);
    endfunction

    // entered and left at a falling edge, valid left high for the next transaction
    task automatic drive_sample(input sample_t s, input logic typed, input result_t want);
        result_t predicted;
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            sample_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < src_idle_pct);
        end
        sample       <= s;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (!sample_ready);
        predicted = advance_estimate(s);
        expected_results = {expected_results, (typed ? want : predicted)};
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic send_random(input sample_t s);
        drive_sample(s, 1'b0, '0);
    endtask

    task automatic send_trajectory();
        int                len;
        int                mode;
        logic [TIME_W-1:0] t;
        logic [POS_W-1:0]  mag;
        logic              sgn;
        sample_t           s;
        len = $urandom_range(2, 14);
        t   = $urandom;
        sgn = 1'($urandom_range(0, 1));
        for (int i = 0; i < len; i++)
        begin
            s.run_start = (i == 0);
            if (i != 0 && $urandom_range(0, 24) == 0)
                s.run_start = 1'b1;
            if ($urandom_range(0, 15) == 0)
                t = $urandom;
            else if ($urandom_range(0, 3) == 0)
                t = t + $urandom_range(1, 16);
            else
                t = t + $urandom_range(1, 1 << 22);
            if ($urandom_range(0, 2) != 0)
                sgn = ~sgn;
            mode = $urandom_range(0, 9);
            if (mode == 0)
                s.position = '0;
            else if (mode == 1)
                s.position = sgn ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
            else
            begin
                if (mode < 5)
                    mag = $urandom_range(1, 255);
                else
                    mag = {1'b0, 31'($urandom)} | 32'd1;
                s.position = sgn ? (POS_W'(0) - mag) : mag;
            end
            s.sample_time = t;
            send_random(s);
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
            result_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_checked++;
            if (expected_results.size() == 0)
                flag_error($sformatf("result with none pending: period=%h valid=%b count=%0d",
                                     result.period, result.period_valid,
                                     result.crossings_seen));
            else
            begin
                want = expected_results.pop_front();
                if (result.period !== want.period || result.period_valid !== want.period_valid
                    || result.crossings_seen !== want.crossings_seen)
                    flag_error($sformatf({"result %0d: expected period=%h valid=%b count=%0d,",
                                          " got period=%h valid=%b count=%0d"},
                                         results_checked, want.period, want.period_valid,
                                         want.crossings_seen, result.period,
                                         result.period_valid, result.crossings_seen));
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        sample_t s;
        rst_n            = 1'b0;
        sample_valid     = 1'b0;
        sample           = '0;
        result_ready     = 1'b0;
        src_idle_pct     = 33;
        snk_idle_pct     = 55;
        samples_sent     = 0;
        results_checked  = 0;
        mismatch_count   = 0;
        periods_measured = 0;
        both_zero_pairs  = 0;
        backward_pairs   = 0;
        est_prev_time    = '0;
        est_prev_pos     = '0;
        est_have_prev    = 1'b0;
        est_count        = '0;
        est_first        = '0;
        est_period       = '0;

        // first sample after reset without a start, then extremes, exact zeros,
        // zero-zero pairs, backward time, crossings past the third, start clearing
        directed_rows = '{
            '{'{1'b0, 32'h0000_0100, 32'sh7fff_ffff}, 1'b1, '{32'h0, 1'b0, 2'd0}},
            '{'{1'b0, 32'h0000_0200, 32'sh8000_0000}, 1'b0, '0},
            '{'{1'b0, 32'h0000_0300, 32'sh0000_0000}, 1'b0, '0},
            '{'{1'b0, 32'h0000_0400, 32'sh0000_0000}, 1'b0, '0},
            '{'{1'b0, 32'h0000_0500, 32'shffff_ffff}, 1'b0, '0},
            '{'{1'b1, 32'hffff_ffff, 32'sh0000_0005}, 1'b1, '{32'h0, 1'b0, 2'd0}},
            '{'{1'b0, 32'h0000_0000, 32'shffff_fffb}, 1'b0, '0},
            '{'{1'b0, 32'h0000_0010, 32'sh0000_0003}, 1'b0, '0},
            '{'{1'b0, 32'h0000_0008, 32'shffff_fffd}, 1'b0, '0},
            '{'{1'b1, 32'h0000_0000, 32'sh0000_0000}, 1'b1, '{32'h0, 1'b0, 2'd0}},
            '{'{1'b0, 32'h0000_0000, 32'sh0000_0000}, 1'b0, '0},
            '{'{1'b0, 32'hffff_ffff, 32'sh7fff_ffff}, 1'b0, '0},
            '{'{1'b0, 32'hffff_ffff, 32'sh0000_0001}, 1'b0, '0},
            '{'{1'b1, 32'h0000_1234, 32'shffff_ffff}, 1'b1, '{32'h0, 1'b0, 2'd0}},
            '{'{1'b1, 32'haaaa_5555, 32'sh5555_5555}, 1'b1, '{32'h0, 1'b0, 2'd0}},
            '{'{1'b0, 32'h5555_aaaa, 32'shaaaa_aaaa}, 1'b0, '0}
        };

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            drive_sample(directed_rows[i].s, directed_rows[i].typed, directed_rows[i].want);

        while (samples_sent < NUM_DIRECTED + RANDOM_ITEMS)
        begin
            if (samples_sent >= NUM_DIRECTED + 2 * RANDOM_ITEMS / 3)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            else if (samples_sent >= NUM_DIRECTED + RANDOM_ITEMS / 3)
            begin
                src_idle_pct = 55;
                snk_idle_pct = 33;
            end
            if ($urandom_range(0, 5) == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    s.run_start   = 1'($urandom_range(0, 1));
                    s.sample_time = $urandom;
                    s.position    = $urandom;
                    send_random(s);
                end
            end
            else
                send_trajectory();
        end
        sample_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (expected_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_results.size()));

        $display("covered %0d samples and %0d results, %0d periods measured",
                 samples_sent, results_checked, periods_measured);
        $display("including %0d zero-zero pairs and %0d crossings with time running backward",
                 both_zero_pairs, backward_pairs);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
